// ===== rtl/kphid_pkg.sv =====
// Shared constants, types and the usage code table of the keypad to report slot block.
package kphid_pkg;

  localparam int NUM_KEYS         = 16;
  localparam int SLOTS_PER_REPORT = 6;
  localparam int NUM_REPORTS      = 2;
  localparam int SCAN_BITS        = 16;
  localparam int OUT_SLOTS        = 6;
  localparam int MAX_RESULTS      = 2;
  localparam int CODE_W           = 8;

  localparam int TOTAL_SLOTS = NUM_REPORTS * SLOTS_PER_REPORT;
  localparam int KEYS        = (NUM_KEYS < SCAN_BITS) ? NUM_KEYS : SCAN_BITS;
  localparam int KEY_W       = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int SCAN_IDX_W  = $clog2(SCAN_BITS);
  localparam int RPT_W       = (NUM_REPORTS > 1) ? $clog2(NUM_REPORTS) : 1;
  localparam int SENT_W      = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  typedef logic [CODE_W-1:0] code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             clear;
    logic             step;
    logic             press;
    logic [KEY_W-1:0] key;
    logic             emit;
    logic [RPT_W-1:0] rpt;
    logic             last;
  } kphid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [NUM_REPORTS-1:0] changed;
    logic                   out_free;
  } kphid_sts_t;

  // Standard keypad usage code of each key position.
  function automatic code_t usage_code(input logic [SCAN_IDX_W-1:0] key);
    code_t code;
    case (key)
      4'd0:    code = 8'h62;
      4'd1:    code = 8'h63;
      4'd2:    code = 8'h55;
      4'd3:    code = 8'h58;
      4'd4:    code = 8'h59;
      4'd5:    code = 8'h5A;
      4'd6:    code = 8'h5B;
      4'd7:    code = 8'h57;
      4'd8:    code = 8'h5C;
      4'd9:    code = 8'h5D;
      4'd10:   code = 8'h5E;
      4'd11:   code = 8'h56;
      4'd12:   code = 8'h5F;
      4'd13:   code = 8'h60;
      4'd14:   code = 8'h61;
      4'd15:   code = 8'h53;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/kphid_if.sv =====
// Valid/ready channel interfaces for keypad scans and keyboard report requests.
interface kphid_in_if;
  import kphid_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SCAN_BITS-1:0] key_pressed;
  logic                 link_up;

  modport source (output valid, output key_pressed, output link_up, input ready);
  modport sink   (input valid, input key_pressed, input link_up, output ready);
endinterface

interface kphid_out_if;
  import kphid_pkg::*;

  logic  valid;
  logic  ready;
  logic  report_index;
  code_t slot_0;
  code_t slot_1;
  code_t slot_2;
  code_t slot_3;
  code_t slot_4;
  code_t slot_5;
  logic  last;

  modport source (output valid, output report_index, output slot_0, output slot_1,
                  output slot_2, output slot_3, output slot_4, output slot_5,
                  output last, input ready);
  modport sink   (input valid, input report_index, input slot_0, input slot_1,
                  input slot_2, input slot_3, input slot_4, input slot_5,
                  input last, output ready);
endinterface

// ===== rtl/kphid_dp.sv =====
// Datapath: scan registers, report slot store, slot search and output register.
module kphid_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [kphid_pkg::SCAN_BITS-1:0] key_pressed,
  input  kphid_pkg::kphid_cmd_t          cmd,
  output kphid_pkg::kphid_sts_t          sts,
  kphid_out_if.source                    out_report
);
  import kphid_pkg::*;

  logic [SCAN_BITS-1:0]   prev_r;
  logic [SCAN_BITS-1:0]   scan_r;
  logic [SCAN_BITS-1:0]   diff_r;
  code_t                  slots_r [TOTAL_SLOTS];
  logic [NUM_REPORTS-1:0] changed_r;

  logic                   out_valid_r;
  logic                   out_rpt_r;
  logic                   out_last_r;
  code_t                  out_slots_r [OUT_SLOTS];

  logic [SCAN_IDX_W-1:0]  key_idx;
  logic                   key_hit;
  code_t                  code;
  code_t                  match_val;
  code_t                  put_val;
  logic [TOTAL_SLOTS-1:0] match_vec;
  logic [TOTAL_SLOTS-1:0] first_vec;
  logic [TOTAL_SLOTS-1:0] write_vec;
  logic [NUM_REPORTS-1:0] hit_rpt;
  code_t                  sel_slots [OUT_SLOTS];

  // Slot search for the key under examination: a release looks for its code,
  // a press looks for an empty slot. The lowest matching slot wins.
  always_comb begin
    key_idx   = SCAN_IDX_W'(cmd.key);
    key_hit   = diff_r[key_idx] && (scan_r[key_idx] == cmd.press);
    code      = usage_code(key_idx);
    match_val = cmd.press ? '0 : code;
    put_val   = cmd.press ? code : '0;
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      match_vec[s] = (slots_r[s] == match_val);
    end
    first_vec = match_vec & (~match_vec + TOTAL_SLOTS'(1));
    write_vec = (cmd.step && key_hit) ? first_vec : '0;
    for (int r = 0; r < NUM_REPORTS; r++) begin
      hit_rpt[r] = |write_vec[r*SLOTS_PER_REPORT +: SLOTS_PER_REPORT];
    end
  end

  // Pick the slots of the report that is to be sent.
  always_comb begin
    for (int s = 0; s < OUT_SLOTS; s++) begin
      sel_slots[s] = '0;
    end
    for (int r = 0; r < NUM_REPORTS; r++) begin
      if (cmd.rpt == RPT_W'(r)) begin
        for (int s = 0; s < OUT_SLOTS; s++) begin
          if (s < SLOTS_PER_REPORT) begin
            sel_slots[s] = slots_r[r*SLOTS_PER_REPORT + s];
          end
        end
      end
    end
  end

  // Scan capture and previous scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.capture) begin
      prev_r <= cmd.clear ? '0 : key_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_r <= key_pressed;
      diff_r <= key_pressed ^ prev_r;
    end
  end

  // Report slot store.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int s = 0; s < TOTAL_SLOTS; s++) begin
        slots_r[s] <= '0;
      end
    end else begin
      for (int s = 0; s < TOTAL_SLOTS; s++) begin
        if (write_vec[s]) begin
          slots_r[s] <= put_val;
        end
      end
    end
  end

  // Reports touched by the current scan.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.capture) begin
      changed_r <= '0;
    end else begin
      changed_r <= changed_r | hit_rpt;
    end
  end

  // Output register: holds one report request until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_report.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rpt_r  <= cmd.rpt[0];
      out_last_r <= cmd.last;
      for (int s = 0; s < OUT_SLOTS; s++) begin
        out_slots_r[s] <= sel_slots[s];
      end
    end
  end

  assign sts.changed  = changed_r;
  assign sts.out_free = !out_valid_r || out_report.ready;

  assign out_report.valid        = out_valid_r;
  assign out_report.report_index = out_rpt_r;
  assign out_report.slot_0       = out_slots_r[0];
  assign out_report.slot_1       = out_slots_r[1];
  assign out_report.slot_2       = out_slots_r[2];
  assign out_report.slot_3       = out_slots_r[3];
  assign out_report.slot_4       = out_slots_r[4];
  assign out_report.slot_5       = out_slots_r[5];
  assign out_report.last         = out_last_r;

endmodule

// ===== rtl/kphid_ctrl.sv =====
// Controller: walks the released and pressed keys, then sends the changed reports.
module kphid_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_link_up,
  output logic                  in_ready,
  input  kphid_pkg::kphid_sts_t sts,
  output kphid_pkg::kphid_cmd_t cmd
);
  import kphid_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_REL, ST_PRS, ST_EMIT} state_t;

  localparam logic [KEY_W-1:0]  KEY_LAST  = KEY_W'(KEYS - 1);
  localparam logic [RPT_W-1:0]  RPT_LAST  = RPT_W'(NUM_REPORTS - 1);
  localparam logic [SENT_W-1:0] SENT_LAST = SENT_W'(MAX_RESULTS - 1);

  state_t            state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [RPT_W-1:0]  rpt_r, rpt_nxt;
  logic [SENT_W-1:0] sent_r, sent_nxt;
  logic              accept;
  logic              higher;
  logic              last_emit;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    rpt_nxt     = rpt_r;
    sent_nxt    = sent_r;
    cmd         = '0;
    cmd.key     = key_r;
    cmd.rpt     = rpt_r;
    cmd.press   = (state_r == ST_PRS);

    // Is any report above the current one still to be sent?
    higher = 1'b0;
    for (int r = 0; r < NUM_REPORTS; r++) begin
      if ((RPT_W'(r) > rpt_r) && sts.changed[r]) begin
        higher = 1'b1;
      end
    end
    last_emit = !higher || (sent_r == SENT_LAST);
    cmd.last  = last_emit;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cmd.clear   = !in_link_up;
          key_nxt     = '0;
          if (in_link_up) begin
            state_nxt = ST_REL;
          end
        end
      end
      ST_REL: begin
        cmd.step = 1'b1;
        if (key_r == KEY_LAST) begin
          key_nxt   = '0;
          state_nxt = ST_PRS;
        end else begin
          key_nxt = key_r + KEY_W'(1);
        end
      end
      ST_PRS: begin
        cmd.step = 1'b1;
        if (key_r == KEY_LAST) begin
          key_nxt   = '0;
          rpt_nxt   = '0;
          sent_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          key_nxt = key_r + KEY_W'(1);
        end
      end
      ST_EMIT: begin
        if (sts.changed[rpt_r]) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            if (last_emit) begin
              state_nxt = ST_IDLE;
            end else begin
              rpt_nxt  = rpt_r + RPT_W'(1);
              sent_nxt = sent_r + SENT_W'(1);
            end
          end
        end else if (rpt_r == RPT_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          rpt_nxt = rpt_r + RPT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r   <= '0;
      rpt_r   <= '0;
      sent_r  <= '0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      rpt_r   <= rpt_nxt;
      sent_r  <= sent_nxt;
    end
  end

`ifndef SYNTHESIS
  // A report is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("report loaded while output register busy");

  // The final report of a scan returns the controller to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == ST_IDLE))
    else $error("controller not idle after final report");

  // The end of the press pass starts sending from the lowest report.
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRS && key_r == KEY_LAST) |=>
      (state_r == ST_EMIT && rpt_r == '0 && sent_r == '0))
    else $error("send phase did not start from report zero");
`endif

endmodule

// ===== rtl/keypad_scan_to_hid_slots_core.sv =====
// Top level: keypad scans in, keyboard report slot requests out.
//
// Each scan request carries a full 16-key keypad image and a link flag. With the
// link down the previous scan and every report slot are cleared and nothing is
// sent. With the link up the controller visits every key twice, once for releases
// and once for presses, one key per cycle, then checks each report in the send
// phase and sends the changed ones, waiting while the sink holds off a report.
// Each visit searches all slots at once and updates at most one. A request is taken
// only while the block is idle, but a finished report waits in its own output
// register, so the next scan can be accepted before the sink has taken it.
module keypad_scan_to_hid_slots_core (
  input  logic        clk,
  input  logic        rst_n,
  kphid_in_if.sink    in_scan,
  kphid_out_if.source out_report
);
  import kphid_pkg::*;

  kphid_cmd_t cmd;
  kphid_sts_t sts;
  logic       in_ready;

  assign in_scan.ready = in_ready;

  kphid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_scan.valid),
    .in_link_up (in_scan.link_up),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  kphid_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_pressed (in_scan.key_pressed),
    .cmd         (cmd),
    .sts         (sts),
    .out_report  (out_report)
  );

endmodule
